@@ sv/irp_pkg.sv @@
// irp_pkg: shared types and constants of the image result packet parser
// no dependencies; used by the interfaces and every module of the block
package irp_pkg;

  localparam int HEADER_BYTES = 40;
  localparam int META_BYTES   = 32;
  localparam int BOX_BYTES    = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [9:0]  CONF_MAX   = 10'd1000;
  localparam logic [32:0] COUNT_MAX  = {33{1'b1}};
  localparam logic [7:0]  SOI_FIRST  = 8'hFF;
  localparam logic [7:0]  SOI_SECOND = 8'hD8;

  // record kinds
  localparam logic [1:0] KIND_BOX     = 2'd0;
  localparam logic [1:0] KIND_JPEG    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_HEADER    = 4'd1;
  localparam logic [3:0] ST_NOT_IMAGE = 4'd2;
  localparam logic [3:0] ST_SHORT     = 4'd3;
  localparam logic [3:0] ST_SIZES     = 4'd4;
  localparam logic [3:0] ST_DIMS      = 4'd5;
  localparam logic [3:0] ST_LENGTH    = 4'd6;
  localparam logic [3:0] ST_BOX       = 4'd7;
  localparam logic [3:0] ST_JPEG      = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VER_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VER_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LIMIT = 3'd5;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_META   = 5'b00010,
    PH_BOXES  = 5'b00100,
    PH_JPEG   = 5'b01000,
    PH_DRAIN  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] version_one;
    logic [15:0] version_two;
    logic [15:0] image_type_code;
    logic [15:0] jpeg_format_code;
    logic [15:0] box_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  status;
    logic [31:0] frame_number;
    logic [63:0] capture_time_us;
    logic [15:0] primary_class;
    logic [9:0]  primary_confidence;
    logic [15:0] inference_time_ms;
    logic [15:0] box_tag;
    logic [9:0]  box_score;
    logic [63:0] packed_geometry;
    logic [15:0] box_flag_bits;
    logic [7:0]  jpeg_data;
  } rec_t;

  // one queue entry: one or two records caused by one byte
  typedef struct packed {
    rec_t rec_a;
    logic has_b;
    rec_t rec_b;
  } entry_t;

endpackage

@@ sv/irp_ifs.sv @@
// irp_ifs: handshake channels of the packet parser (bytes, records, config)
// depends on irp_pkg
interface irp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface irp_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  status;
  logic [31:0] frame_number;
  logic [63:0] capture_time_us;
  logic [15:0] primary_class;
  logic [9:0]  primary_confidence;
  logic [15:0] inference_time_ms;
  logic [15:0] box_tag;
  logic [9:0]  box_score;
  logic [63:0] packed_geometry;
  logic [15:0] box_flag_bits;
  logic [7:0]  jpeg_data;
  modport source (output valid, kind, status, frame_number, capture_time_us, primary_class,
                  primary_confidence, inference_time_ms, box_tag, box_score,
                  packed_geometry, box_flag_bits, jpeg_data, input ready);
  modport sink   (input valid, kind, status, frame_number, capture_time_us, primary_class,
                  primary_confidence, inference_time_ms, box_tag, box_score,
                  packed_geometry, box_flag_bits, jpeg_data, output ready);
endinterface

interface irp_cfg_if;
  import irp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/irp_front.sv @@
// irp_front: byte parser; assembles fields, checks them, builds records
// depends on irp_pkg; feeds irp_queue
module irp_front (
  input  logic          clk,
  input  logic          rst,
  input  irp_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          q_full,
  output logic          in_ready,
  output logic          push,
  output irp_pkg::entry_t push_entry
);
  import irp_pkg::*;

  phase_t      phase, phase_next;
  logic [5:0]  off, off_next;
  logic [31:0] magic, magic_next, hsize, hsize_next;
  logic [15:0] pver, pver_next, ptype, ptype_next, img_w, img_w_next, img_h, img_h_next;
  logic [15:0] pfmt, pfmt_next;
  logic [31:0] frame, frame_next, jlen, jlen_next, jleft, jleft_next;
  logic [63:0] cap, cap_next, asmb, asmb_next, boxb, boxb_next;
  logic [15:0] nbox, nbox_next, bleft, bleft_next;
  logic [47:0] cct, cct_next, boxx, boxx_next;
  logic [32:0] pcount, pcount_next;
  logic [3:0]  fault, fault_next;
  logic [1:0]  jseen, jseen_next;
  logic        box_bad, box_bad_next, jpeg_bad, jpeg_bad_next;

  logic        accept, ver_ok, emit, bad;
  logic [5:0]  off_m4, off_m18, off_m2, off_m8;
  logic [15:0] score, x1, y1, x2, y2;
  rec_t        rec_e, rec_s;
  logic [19:0] nb14;
  logic [32:0] expect_cnt;
  logic [3:0]  st;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign off_m4   = off - 6'd4;
  assign off_m18  = off - 6'd18;
  assign off_m2   = off - 6'd2;
  assign off_m8   = off - 6'd8;

  always_comb begin
    phase_next = phase; off_next = off;
    magic_next = magic; hsize_next = hsize; pver_next = pver; ptype_next = ptype;
    img_w_next = img_w; img_h_next = img_h; pfmt_next = pfmt;
    frame_next = frame; jlen_next = jlen; jleft_next = jleft; cap_next = cap;
    asmb_next = asmb; boxb_next = boxb; nbox_next = nbox; bleft_next = bleft;
    cct_next = cct; boxx_next = boxx; fault_next = fault; jseen_next = jseen;
    box_bad_next = box_bad; jpeg_bad_next = jpeg_bad;
    pcount_next = pcount;
    emit = 1'b0; bad = 1'b0;
    rec_e = '0;
    ver_ok = (ptype == cfg.image_type_code) ?
             (pver == cfg.version_one || pver == cfg.version_two) :
             (pver == cfg.version_one);
    if (phase != PH_HEADER && pcount != COUNT_MAX) pcount_next = pcount + 33'd1;
    score = '0; x1 = '0; y1 = '0; x2 = '0; y2 = '0;

    unique case (phase)
      PH_HEADER: begin
        if (off < 6'd4) magic_next[off[1:0]*8 +: 8] = in_byte;
        else if (off < 6'd6) pver_next[off[0]*8 +: 8] = in_byte;
        else if (off < 6'd8) ptype_next[off[0]*8 +: 8] = in_byte;
        else if (off < 6'd12) hsize_next[off[1:0]*8 +: 8] = in_byte;
        else if (off == 6'd28 || off == 6'd29) img_w_next[off[0]*8 +: 8] = in_byte;
        else if (off == 6'd30 || off == 6'd31) img_h_next[off[0]*8 +: 8] = in_byte;
        else if (off == 6'd32 || off == 6'd33) pfmt_next[off[0]*8 +: 8] = in_byte;
        if (off >= 6'(HEADER_BYTES - 1)) begin
          off_next = '0;
          if (magic != cfg.expected_magic || !ver_ok || hsize != 32'(HEADER_BYTES))
            fault_next = ST_HEADER;
          else if (pver != cfg.version_two || ptype != cfg.image_type_code ||
                   pfmt != cfg.jpeg_format_code || img_w == '0 || img_h == '0)
            fault_next = ST_NOT_IMAGE;
          phase_next = (fault_next != ST_OK) ? PH_DRAIN : PH_META;
        end else begin
          off_next = off + 6'd1;
        end
      end
      PH_META: begin
        if (off < 6'd4) frame_next[off[1:0]*8 +: 8] = in_byte;
        else if (off < 6'd12) cap_next[off_m4[2:0]*8 +: 8] = in_byte;
        else if (off < 6'd16) jlen_next[off[1:0]*8 +: 8] = in_byte;
        else if (off < 6'd18) nbox_next[off[0]*8 +: 8] = in_byte;
        else if (off < 6'd24) cct_next[off_m18[2:0]*8 +: 8] = in_byte;
        else asmb_next[off[2:0]*8 +: 8] = in_byte;
        if (off >= 6'(META_BYTES - 1)) begin
          off_next = '0;
          if (asmb_next[47:32] != 16'(META_BYTES) || asmb_next[63:48] != 16'(BOX_BYTES) ||
              nbox > cfg.box_limit) begin
            fault_next = ST_SIZES; phase_next = PH_DRAIN;
          end else if (asmb_next[15:0] != img_w || asmb_next[31:16] != img_h) begin
            fault_next = ST_DIMS; phase_next = PH_DRAIN;
          end else begin
            if (jlen < 32'd2) jpeg_bad_next = 1'b1;
            bleft_next = nbox;
            if (nbox != '0) phase_next = PH_BOXES;
            else if (jlen != '0) begin
              phase_next = PH_JPEG; jleft_next = jlen; jseen_next = '0;
            end else phase_next = PH_DRAIN;
          end
        end else begin
          off_next = off + 6'd1;
        end
      end
      PH_BOXES: begin
        if (off == 6'd0) boxx_next[15:8] = in_byte;
        else if (off == 6'd1) boxx_next[7:0] = in_byte;
        else if (off < 6'd10) boxb_next[off_m2[2:0]*8 +: 8] = in_byte;
        else boxx_next[off_m8[2:0]*8 +: 8] = in_byte;
        if (off >= 6'(BOX_BYTES - 1)) begin
          score = boxb_next[15:0]; x1 = boxb_next[31:16];
          y1 = boxb_next[47:32]; x2 = boxb_next[63:48]; y2 = boxx_next[31:16];
          bad = score > 16'(CONF_MAX) || x1 > x2 || y1 > y2 ||
                x2 >= asmb[15:0] || y2 >= asmb[31:16];
          emit = 1'b1;
          rec_e.kind = KIND_BOX;
          rec_e.status = bad ? ST_BOX : ST_OK;
          rec_e.box_tag = boxx_next[15:0];
          rec_e.box_score = (score > 16'(CONF_MAX)) ? CONF_MAX : score[9:0];
          rec_e.packed_geometry = {y2, x2, y1, x1};
          rec_e.box_flag_bits = boxx_next[47:32];
          if (bad) box_bad_next = 1'b1;
          off_next = '0; boxb_next = '0; boxx_next = '0;
          if (bleft != '0) bleft_next = bleft - 16'd1;
          if (bleft_next == '0) begin
            if (jlen != '0) begin
              phase_next = PH_JPEG; jleft_next = jlen; jseen_next = '0;
            end else phase_next = PH_DRAIN;
          end
        end else begin
          off_next = off + 6'd1;
        end
      end
      PH_JPEG: begin
        if (jseen == 2'd0 && in_byte != SOI_FIRST) jpeg_bad_next = 1'b1;
        if (jseen == 2'd1 && in_byte != SOI_SECOND) jpeg_bad_next = 1'b1;
        if (jseen != 2'd2) jseen_next = jseen + 2'd1;
        emit = 1'b1;
        rec_e.kind = KIND_JPEG;
        rec_e.jpeg_data = in_byte;
        if (jleft != '0) jleft_next = jleft - 32'd1;
        if (jleft_next == '0) phase_next = PH_DRAIN;
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  // summary from the state as left by this byte
  always_comb begin
    nb14 = 20'({nbox_next, 4'b0}) - 20'({nbox_next, 1'b0});
    expect_cnt = 33'(META_BYTES) + 33'(nb14) + 33'(jlen_next);
    if (phase_next == PH_HEADER) st = ST_HEADER;
    else if (fault_next != ST_OK) st = fault_next;
    else if (pcount_next < 33'(META_BYTES)) st = ST_SHORT;
    else if (expect_cnt != pcount_next) st = ST_LENGTH;
    else if (box_bad_next) st = ST_BOX;
    else if (jpeg_bad_next) st = ST_JPEG;
    else st = ST_OK;
    rec_s = '0;
    rec_s.kind = KIND_SUMMARY;
    rec_s.status = st;
    if (st == ST_OK) begin
      rec_s.frame_number = frame_next;
      rec_s.capture_time_us = cap_next;
      rec_s.primary_class = cct_next[15:0];
      rec_s.primary_confidence = (cct_next[31:16] > 16'(CONF_MAX)) ?
                                 CONF_MAX : cct_next[25:16];
      rec_s.inference_time_ms = cct_next[47:32];
      rec_s.packed_geometry = {32'd0, asmb_next[31:0]};
    end
  end

  always_comb begin
    push = accept && (emit || in_last);
    push_entry.rec_a = emit ? rec_e : rec_s;
    push_entry.has_b = emit && in_last;
    push_entry.rec_b = rec_s;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      phase <= PH_HEADER; off <= '0;
      magic <= '0; hsize <= '0; pver <= '0; ptype <= '0;
      img_w <= '0; img_h <= '0; pfmt <= '0;
      frame <= '0; jlen <= '0; jleft <= '0; cap <= '0;
      asmb <= '0; boxb <= '0; nbox <= '0; bleft <= '0;
      cct <= '0; boxx <= '0; pcount <= '0; fault <= ST_OK; jseen <= '0;
      box_bad <= 1'b0; jpeg_bad <= 1'b0;
    end else if (accept) begin
      phase <= phase_next; off <= off_next;
      magic <= magic_next; hsize <= hsize_next; pver <= pver_next; ptype <= ptype_next;
      img_w <= img_w_next; img_h <= img_h_next; pfmt <= pfmt_next;
      frame <= frame_next; jlen <= jlen_next; jleft <= jleft_next; cap <= cap_next;
      asmb <= asmb_next; boxb <= boxb_next; nbox <= nbox_next; bleft <= bleft_next;
      cct <= cct_next; boxx <= boxx_next; pcount <= pcount_next; fault <= fault_next;
      jseen <= jseen_next; box_bad <= box_bad_next; jpeg_bad <= jpeg_bad_next;
    end
  end

endmodule

@@ sv/irp_queue.sv @@
// irp_queue: short entry queue between the parser and the output stage
// depends on irp_pkg
module irp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  irp_pkg::entry_t push_entry,
  input  logic            pop,
  output irp_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import irp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

@@ sv/irp_back.sv @@
// irp_back: output stage; splits queue entries into single records
// depends on irp_pkg; reads from irp_queue
module irp_back (
  input  logic            clk,
  input  logic            rst,
  input  irp_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output irp_pkg::rec_t   out_rec
);
  import irp_pkg::*;

  logic second, load;

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && (second || !head.has_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; second <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load) second <= !second && head.has_b;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_rec <= second ? head.rec_b : head.rec_a;
  end

endmodule

@@ sv/image_result_packet_parser_unit.sv @@
// image_result_packet_parser_unit: top level of the image result packet parser
// depends on irp_pkg, irp_ifs, irp_front, irp_queue, irp_back
//
// usage
//   pkt : one packet byte per item, last_byte marks the final byte
//   rec : result items; box records, passed jpeg bytes, one summary per packet
//   cfg : register writes (index, data), always ready; write only while idle
// throughput: one byte per cycle; the parser takes a byte every cycle while
//   the queue has room; a final byte that also ends a box or jpeg byte gives
//   two items, which the output stage sends one after the other
// path: a record is written into the queue as its byte is taken, then loaded
//   into the output register once that register is free, and is shown on rec
// reset: rst (synchronous) returns the parser to the header phase, empties
//   the queue and loads the register defaults
// stall: when rec.ready is low the output register holds, the queue fills
//   (QUEUE_DEPTH entries) and then pkt.ready drops until room returns
module image_result_packet_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  irp_byte_if.sink   pkt,
  irp_rec_if.source  rec,
  irp_cfg_if.sink    cfg
);
  import irp_pkg::*;

  cfg_t   regs;
  entry_t push_entry, head;
  rec_t   out_rec;
  logic   push, pop, q_empty, q_full;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_magic   <= '0;
      regs.version_one      <= 16'd1;
      regs.version_two      <= 16'd2;
      regs.image_type_code  <= '0;
      regs.jpeg_format_code <= '0;
      regs.box_limit        <= 16'd32;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAGIC:     regs.expected_magic   <= cfg.data;
        REG_VER_ONE:   regs.version_one      <= cfg.data[15:0];
        REG_VER_TWO:   regs.version_two      <= cfg.data[15:0];
        REG_TYPE:      regs.image_type_code  <= cfg.data[15:0];
        REG_FORMAT:    regs.jpeg_format_code <= cfg.data[15:0];
        REG_BOX_LIMIT: regs.box_limit        <= cfg.data[15:0];
        default: begin
        end
      endcase
    end
  end

  // front: parse and classify each byte
  irp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .in_valid   (pkt.valid),
    .in_byte    (pkt.data_byte),
    .in_last    (pkt.last_byte),
    .q_full     (q_full),
    .in_ready   (pkt.ready),
    .push       (push),
    .push_entry (push_entry)
  );

  // queue decouples the parser from the receiver
  irp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // back: one record per cycle into the output register while the queue holds entries and rec is not stalled
  irp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (rec.valid),
    .out_ready (rec.ready),
    .out_rec   (out_rec)
  );

  assign rec.kind               = out_rec.kind;
  assign rec.status             = out_rec.status;
  assign rec.frame_number       = out_rec.frame_number;
  assign rec.capture_time_us    = out_rec.capture_time_us;
  assign rec.primary_class      = out_rec.primary_class;
  assign rec.primary_confidence = out_rec.primary_confidence;
  assign rec.inference_time_ms  = out_rec.inference_time_ms;
  assign rec.box_tag            = out_rec.box_tag;
  assign rec.box_score          = out_rec.box_score;
  assign rec.packed_geometry    = out_rec.packed_geometry;
  assign rec.box_flag_bits      = out_rec.box_flag_bits;
  assign rec.jpeg_data          = out_rec.jpeg_data;

endmodule

@@ sv/irp_checker.sv @@
// irp_checker: port level checks on the result channel of the parser
// depends on irp_pkg; bound to image_result_packet_parser_unit
module irp_checker (
  input logic        clk,
  input logic        rst,
  input logic        rec_valid,
  input logic        rec_ready,
  input logic [1:0]  kind,
  input logic [3:0]  status,
  input logic [31:0] frame_number,
  input logic [63:0] capture_time_us,
  input logic [9:0]  box_score,
  input logic [63:0] packed_geometry
);
  import irp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(kind) && $stable(status))
    else $error("result item changed while stalled");

  a_fault_summary: assert property (@(posedge clk) disable iff (rst)
    rec_valid && kind == KIND_SUMMARY && status != ST_OK |->
      frame_number == '0 && capture_time_us == '0 && packed_geometry == '0)
    else $error("faulted summary carries data");

  a_box: assert property (@(posedge clk) disable iff (rst)
    rec_valid && kind == KIND_BOX |->
      (status == ST_OK || status == ST_BOX) && box_score <= CONF_MAX)
    else $error("bad box record");

  a_jpeg: assert property (@(posedge clk) disable iff (rst)
    rec_valid && kind == KIND_JPEG |-> status == ST_OK && packed_geometry == '0)
    else $error("bad jpeg record");

endmodule

bind image_result_packet_parser_unit irp_checker u_irp_checker (
  .clk             (clk),
  .rst             (rst),
  .rec_valid       (rec.valid),
  .rec_ready       (rec.ready),
  .kind            (rec.kind),
  .status          (rec.status),
  .frame_number    (rec.frame_number),
  .capture_time_us (rec.capture_time_us),
  .box_score       (rec.box_score),
  .packed_geometry (rec.packed_geometry)
);
